/* rtl/ordered_list_insert_delete_search_macros.svh */
// Assertion macros for the positional list block.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define OLIDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition that must hold in the cycle after its trigger.
`define OLIDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/olids_pkg.sv */
package olids_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 6;
  localparam int STEP_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Control from the sequencer to the cell chain.
  typedef struct packed {
    logic              shift;
    logic [DATA_W-1:0] tail;
  } chain_ctl_t;

endpackage

/* rtl/olids_cell.sv */
module olids_cell
  import olids_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [DATA_W-1:0] data_in,
  output logic [DATA_W-1:0] data
);

  // Take the neighbor's word on every shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= data_in;
    end
  end

endmodule

/* rtl/olids_chain.sv */
module olids_chain
  import olids_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  output logic [DATA_W-1:0] head,
  output logic [DATA_W-1:0] second
);

  logic [DATA_W-1:0] cell_data [DEPTH];

  // Each cell takes the word of the cell above it; the top cell takes the tail word.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] feed;
    if (k == DEPTH - 1) begin : g_top
      assign feed = ctl.tail;
    end else begin : g_mid
      assign feed = cell_data[k+1];
    end
    olids_cell u_cell (
      .clk     (clk),
      .shift   (ctl.shift),
      .data_in (feed),
      .data    (cell_data[k])
    );
  end

  assign head   = cell_data[0];
  assign second = cell_data[1];

endmodule

/* rtl/ordered_list_insert_delete_search.sv */
// Positional list of up to DEPTH signed 32-bit words, held in a ring of cells.
// Input channel: command, value, position with in_valid / in_stall. An item is
// taken when in_valid is high and in_stall is low; one item is worked at a time.
// Output channel: status, position_out, value_out, entry_count, last with
// out_valid / out_stall. Every command ends with exactly one result with last set.
// Rejected commands (full list, bad position, empty list) answer straight from
// idle; their result is registered as they are accepted. Other commands
// rotate the cell ring once around, and insert and delete rewrite the list
// during that pass. Insert, delete and search then enter a closing state that
// registers the final result, waiting there while the output register is
// stalled; display returns to idle straight from the pass.
// Search and display send results during the pass, search its last match
// from the closing state. A display entry, or a search match while an earlier
// match waits, seen while the output register is stalled holds the ring until
// it drains.
// The input stalls while a result waits in a stalled output register; once the
// result can drain, the next item is accepted in that cycle. Reset empties the
// list and drops any result still waiting; the cell contents are not cleared.
`include "ordered_list_insert_delete_search_macros.svh"

module ordered_list_insert_delete_search
  import olids_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic signed [31:0] value,
  input  logic [5:0]        position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [5:0]        position_out,
  output logic signed [31:0] value_out,
  output logic [5:0]        entry_count,
  output logic              last
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  count;
  logic              found;
  logic              pend_v;

  cmd_t              cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [STEP_W-1:0] p_r;
  logic [DATA_W-1:0] carry;
  logic [STEP_W-1:0] at;
  logic [STEP_W-1:0] pend;

  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] second;
  chain_ctl_t        ctl;

  logic              can_emit;
  logic              accept;
  logic              in_range;
  logic              match;
  logic              fnd_now;
  logic              emit;
  status_t           e_status;
  logic [CNT_W-1:0]  e_pos;
  logic [DATA_W-1:0] e_val;
  logic [CNT_W-1:0]  e_cnt;
  logic              e_last;
  logic              full;
  logic              bad_pos;

  olids_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .head   (head),
    .second (second)
  );

  // Handshake on both sides.
  assign can_emit = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && can_emit);
  assign accept   = in_valid && !in_stall;

  assign in_range = CNT_W'(step) < count;
  assign match    = in_range && (head == val_r);
  assign full     = count >= CNT_W'(DEPTH);
  assign bad_pos  = (position == '0) || ({1'b0, position} > ({1'b0, count} + 7'd1));

  // Decide the ring feed and any result of this cycle.
  always_comb begin
    emit      = 1'b0;
    e_status  = STAT_OK;
    e_pos     = '0;
    e_val     = '0;
    e_cnt     = count;
    e_last    = 1'b1;
    ctl.shift = 1'b0;
    ctl.tail  = head;
    fnd_now   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (cmd_t'(command) == CMD_INSERT && full) begin
            emit     = 1'b1;
            e_status = STAT_FULL;
          end else if (cmd_t'(command) == CMD_INSERT && bad_pos) begin
            emit     = 1'b1;
            e_status = STAT_BAD_POS;
          end else if (cmd_t'(command) == CMD_DELETE && count == '0) begin
            emit     = 1'b1;
            e_status = STAT_EMPTY;
          end else if (cmd_t'(command) == CMD_SEARCH && count == '0) begin
            emit     = 1'b1;
            e_status = STAT_NOT_FOUND;
          end else if (cmd_t'(command) == CMD_DISPLAY && count == '0) begin
            emit     = 1'b1;
            e_status = STAT_EMPTY;
          end else begin
            emit = 1'b0;
          end
        end
      end
      S_SCAN: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            ctl.shift = 1'b1;
            if (step < p_r) begin
              ctl.tail = head;
            end else if (step == p_r) begin
              ctl.tail = val_r;
            end else begin
              ctl.tail = carry;
            end
          end
          CMD_DELETE: begin
            ctl.shift = 1'b1;
            fnd_now   = match && !found;
            ctl.tail  = (found || fnd_now) ? second : head;
          end
          CMD_SEARCH: begin
            ctl.shift = !(match && pend_v) || can_emit;
            emit      = match && pend_v && can_emit;
            e_pos     = CNT_W'(pend) + CNT_W'(1);
            e_val     = val_r;
            e_last    = 1'b0;
          end
          CMD_DISPLAY: begin
            ctl.shift = !in_range || can_emit;
            emit      = in_range && can_emit;
            e_pos     = CNT_W'(step) + CNT_W'(1);
            e_val     = head;
            e_last    = (CNT_W'(step) + CNT_W'(1)) == count;
          end
        endcase
      end
      S_DONE: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            emit  = can_emit;
            e_pos = CNT_W'(p_r) + CNT_W'(1);
            e_val = val_r;
            e_cnt = count + CNT_W'(1);
          end
          CMD_DELETE: begin
            emit = can_emit;
            if (found) begin
              e_pos = CNT_W'(at) + CNT_W'(1);
              e_val = val_r;
              e_cnt = count - CNT_W'(1);
            end else begin
              e_status = STAT_NOT_FOUND;
            end
          end
          CMD_SEARCH: begin
            emit = can_emit;
            if (pend_v) begin
              e_pos = CNT_W'(pend) + CNT_W'(1);
              e_val = val_r;
            end else begin
              e_status = STAT_NOT_FOUND;
            end
          end
          CMD_DISPLAY: begin
            emit = 1'b0;
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Advance the sequencer, the list length and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= '0;
      found     <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && !emit) begin
            state  <= S_SCAN;
            step   <= '0;
            found  <= 1'b0;
            pend_v <= 1'b0;
          end
        end
        S_SCAN: begin
          if (ctl.shift) begin
            step <= step + STEP_W'(1);
            if (fnd_now) begin
              found <= 1'b1;
            end
            if (cmd_r == CMD_SEARCH && match) begin
              pend_v <= 1'b1;
            end
            if (step == LAST_STEP) begin
              step  <= '0;
              state <= (cmd_r == CMD_DISPLAY) ? S_IDLE : S_DONE;
            end
          end
        end
        S_DONE: begin
          if (can_emit) begin
            state <= S_IDLE;
            if (cmd_r == CMD_INSERT) begin
              count <= count + CNT_W'(1);
            end else if (cmd_r == CMD_DELETE && found) begin
              count <= count - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the command operands, the insert carry, the match positions and the result fields.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cmd_r <= cmd_t'(command);
      val_r <= value;
      p_r   <= STEP_W'(position - 6'd1);
    end
    if (state == S_SCAN && ctl.shift) begin
      carry <= head;
      if (fnd_now) begin
        at <= step;
      end
      if (cmd_r == CMD_SEARCH && match) begin
        pend <= step;
      end
    end
    if (emit) begin
      status       <= e_status;
      position_out <= e_pos;
      value_out    <= e_val;
      entry_count  <= e_cnt;
      last         <= e_last;
    end
  end

  `OLIDS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "list length above DEPTH")
  `OLIDS_ASSERT_NOW(a_idle_step, state == S_IDLE, step == '0, "step counter not at zero when idle")
  `OLIDS_ASSERT_NOW(a_out_count, out_valid, entry_count == count, "result length differs from list length")
  `OLIDS_ASSERT_NEXT(a_scan_stall, state == S_SCAN && step != LAST_STEP, in_stall, "stall dropped")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import olids_pkg::*;

  // One result the list is due to send back
  typedef struct {
    status_t           st;
    logic [5:0]        pos;
    logic signed [31:0] val;
    logic [5:0]        cnt;
    logic              fin;
  } list_result_t;

  // Shadow copy of the list and the results it owes
  class list_scoreboard;
    logic signed [31:0] entries [DEPTH];
    int                 count;
    list_result_t       awaited[$];
    int                 errors;
    int                 checked;
    int                 peak_count;
    int                 full_hits;
    int                 bad_pos_hits;
    int                 cmd_seen [4];

    function void push_result(status_t st, int pos, logic signed [31:0] val,
                              logic fin);
      list_result_t r;
      r.st  = st;
      r.pos = pos[5:0];
      r.val = val;
      r.cnt = count[5:0];
      r.fin = fin;
      awaited.push_back(r);
    endfunction

    // Apply one accepted command to the shadow list
    function void note_command(cmd_t c, logic signed [31:0] v, logic [5:0] p);
      int i;
      int at;
      bit hit;
      cmd_seen[c]++;
      case (c)
        CMD_INSERT: begin
          if (count >= DEPTH) begin
            full_hits++;
            push_result(STAT_FULL, 0, 0, 1'b1);
          end else if (p < 1 || p > count + 1) begin
            bad_pos_hits++;
            push_result(STAT_BAD_POS, 0, 0, 1'b1);
          end else begin
            for (i = count; i >= p; i--) entries[i] = entries[i-1];
            entries[p-1] = v;
            count++;
            if (count > peak_count) peak_count = count;
            push_result(STAT_OK, p, v, 1'b1);
          end
        end
        CMD_DELETE: begin
          if (count == 0) begin
            push_result(STAT_EMPTY, 0, 0, 1'b1);
          end else begin
            at = -1;
            for (i = 0; i < count && at < 0; i++)
              if (entries[i] === v) at = i;
            if (at < 0) begin
              push_result(STAT_NOT_FOUND, 0, 0, 1'b1);
            end else begin
              for (i = at; i + 1 < count; i++) entries[i] = entries[i+1];
              count--;
              push_result(STAT_OK, at + 1, v, 1'b1);
            end
          end
        end
        CMD_SEARCH: begin
          hit = 1'b0;
          for (i = 0; i < count; i++) begin
            if (entries[i] === v) begin
              push_result(STAT_OK, i + 1, v, 1'b0);
              hit = 1'b1;
            end
          end
          if (hit) awaited[awaited.size()-1].fin = 1'b1;
          else push_result(STAT_NOT_FOUND, 0, 0, 1'b1);
        end
        default: begin
          if (count == 0) push_result(STAT_EMPTY, 0, 0, 1'b1);
          else for (i = 0; i < count; i++)
            push_result(STAT_OK, i + 1, entries[i], i + 1 == count);
        end
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(logic [2:0] st, logic [5:0] pos,
                               logic signed [31:0] val, logic [5:0] cnt, logic fin);
      list_result_t e;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected result, status %0d position %0d value %0h",
                   $time, st, pos, val);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.st)   report("status", e.st, st);
      if (pos !== e.pos) report("position_out", e.pos, pos);
      if (val !== e.val) report("value_out", e.val, val);
      if (cnt !== e.cnt) report("entry_count", e.cnt, cnt);
      if (fin !== e.fin) report("last", e.fin, fin);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [31:0] value;
  logic [5:0]         position;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic [5:0]         position_out;
  logic signed [31:0] value_out;
  logic [5:0]         entry_count;
  logic               last;

  list_scoreboard sb = new();
  int             burst_left;
  bit             hold_go;

  ordered_list_insert_delete_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .value        (value),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position_out (position_out),
    .value_out    (value_out),
    .entry_count  (entry_count),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item in bursts; hold it until the block takes it
  task automatic send_item(cmd_t c, logic signed [31:0] v, logic [5:0] p);
    bit taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= c;
    value    <= v;
    position <= p;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_command(c, v, p);
  endtask

  // Pick a value: often one already in the list, else extremes, a small pool or anything
  function automatic logic signed [31:0] pick_value(bit from_list);
    logic signed [31:0] v;
    if (from_list && sb.count > 0 && $urandom_range(0, 3) != 0)
      return sb.entries[$urandom_range(0, sb.count - 1)];
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sh0;
          default: v = -32'sd1;
        endcase
      end
      1, 2: v = $urandom_range(0, 7);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Grow the list to full, then drain it to empty, with noise mixed in
  task automatic run_random(int n);
    bit                 growing;
    int                 k;
    int                 r;
    cmd_t               c;
    logic [5:0]         p;
    logic signed [31:0] v;
    growing = 1'b1;
    for (k = 0; k < n; k++) begin
      if (growing && sb.count == DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
      else if (!growing && sb.count == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      if ($urandom_range(0, 99) < 8) begin
        c = cmd_t'($urandom_range(0, 3));
        v = $urandom;
        p = 6'($urandom_range(0, 63));
      end else begin
        r = $urandom_range(0, 99);
        if (r < (growing ? 65 : 10)) c = CMD_INSERT;
        else if (r < 80) c = CMD_DELETE;
        else if (r < 92) c = CMD_SEARCH;
        else c = CMD_DISPLAY;
        if (c == CMD_INSERT) p = 6'($urandom_range(1, sb.count + 1));
        else p = 6'($urandom_range(0, 63));
        v = pick_value(c != CMD_INSERT || $urandom_range(0, 3) == 0);
      end
      send_item(c, v, p);
    end
  endtask

  // Receiver: stall in random modes, with one long hold-off
  initial begin : receiver
    int stall_pct;
    int mode_left;
    int hold_left;
    bit hold_done;
    stall_pct = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 150);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Check each result in the cycle in which it is taken
  initial begin : monitor
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(status, position_out, value_out, entry_count, last);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results outstanding", sb.awaited.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= CMD_INSERT;
    value      <= '0;
    position   <= '0;
    burst_left = 0;
    hold_go    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list and bad positions
    send_item(CMD_DISPLAY, 0, 0);
    send_item(CMD_DELETE, 1, 0);
    send_item(CMD_SEARCH, 1, 0);
    send_item(CMD_INSERT, 9, 0);
    send_item(CMD_INSERT, 9, 2);
    send_item(CMD_INSERT, 9, 63);
    // Build a list with extremes and a duplicate
    send_item(CMD_INSERT, 32'sh7FFF_FFFF, 1);
    send_item(CMD_INSERT, 32'sh8000_0000, 2);
    send_item(CMD_INSERT, 0, 1);
    send_item(CMD_INSERT, -1, 2);
    send_item(CMD_INSERT, 5, 3);
    send_item(CMD_INSERT, 5, 6);
    send_item(CMD_INSERT, 9, 8);
    // Search and display, duplicates reported at every position
    send_item(CMD_SEARCH, 5, 0);
    send_item(CMD_SEARCH, 32'sh8000_0000, 0);
    send_item(CMD_SEARCH, 123, 0);
    send_item(CMD_DISPLAY, 0, 0);
    // Delete removes the first match only
    send_item(CMD_DELETE, 5, 0);
    send_item(CMD_DELETE, 77, 0);
    send_item(CMD_SEARCH, 5, 0);
    send_item(CMD_DELETE, 32'sh7FFF_FFFF, 0);
    send_item(CMD_INSERT, 32'shAAAA_AAAA, 5);
    send_item(CMD_DISPLAY, 0, 63);

    hold_go = 1'b1;
    run_random(160);
    in_valid <= 1'b0;

    // Drain, then allow a full pass for anything stray
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("commands: %0d insert, %0d delete, %0d search, %0d display; %0d results checked",
             sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DELETE], sb.cmd_seen[CMD_SEARCH],
             sb.cmd_seen[CMD_DISPLAY], sb.checked);
    $display("list peaked at %0d entries; %0d inserts hit a full list, %0d a bad position",
             sb.peak_count, sb.full_hits, sb.bad_pos_hits);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
